### src/ltjc_pkg.sv
// shared types, constants and speed helpers for the line track junction counter
package ltjc_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned TARGET_W    = 4;
  localparam int unsigned SPEED_W     = 8;
  localparam int unsigned OFFSET_W    = 10;
  localparam int unsigned MOTION_W    = 3;
  localparam int unsigned EDGES_W     = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned COUNT_BITS_DEF = 4;
  localparam int unsigned RAMP_STEP   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_OFFSET = 3'd4;

  localparam logic [MODE_W-1:0] MODE_FORWARD      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARKER       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STRAFE_LEFT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STRAFE_RIGHT = 2'd3;

  localparam logic [MODE_W-1:0]   RST_MODE       = MODE_FORWARD;
  localparam logic [TARGET_W-1:0] RST_TARGET     = 4'd4;
  localparam logic [SPEED_W-1:0]  RST_START      = 8'd60;
  localparam logic [SPEED_W-1:0]  RST_FLOOR      = 8'd35;
  localparam logic [OFFSET_W-1:0] RST_END_OFFSET = 10'd110;

  localparam logic [SPEED_W-1:0] TURN_BOOST = 8'd10;

  // per-wheel strafe biases: front left, rear left, front right, rear right
  localparam logic signed [5:0] SL_FL = 6'sd15;
  localparam logic signed [5:0] SL_RL = -6'sd10;
  localparam logic signed [5:0] SL_FR = 6'sd5;
  localparam logic signed [5:0] SL_RR = 6'sd10;
  localparam logic signed [5:0] SR_FL = -6'sd5;
  localparam logic signed [5:0] SR_RL = 6'sd5;
  localparam logic signed [5:0] SR_FR = 6'sd10;
  localparam logic signed [5:0] SR_RR = -6'sd10;

  typedef enum logic [MOTION_W-1:0] {
    MOT_STOP,
    MOT_ADVANCE,
    MOT_TURN_RIGHT,
    MOT_TURN_LEFT,
    MOT_STRAFE_LEFT,
    MOT_STRAFE_RIGHT,
    MOT_HOLD
  } motion_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [TARGET_W-1:0] target;
    logic [SPEED_W-1:0]  start;
    logic [SPEED_W-1:0]  floor;
    logic [OFFSET_W-1:0] end_offset;
  } cfg_t;

  typedef struct packed {
    motion_e             motion;
    logic [SPEED_W-1:0]  fl;
    logic [SPEED_W-1:0]  rl;
    logic [SPEED_W-1:0]  fr;
    logic [SPEED_W-1:0]  rr;
  } move_t;

  typedef struct packed {
    move_t               move;
    logic [EDGES_W-1:0]  edges;
    logic                finished;
    logic                aborted;
    logic [OFFSET_W-1:0] nudge;
  } result_t;

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s,
                                                     input logic signed [5:0] bias,
                                                     input logic [SPEED_W-1:0] floor);
    logic signed [9:0] v;
    logic signed [9:0] lo;
    logic [SPEED_W-1:0] r;
    v  = $signed({2'b00, s}) + $signed({{4{bias[5]}}, bias});
    lo = $signed({2'b00, floor});
    if (v < lo) begin
      r = floor;
    end else if (v > 10'sd255) begin
      r = 8'hFF;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

  function automatic move_t mode_move(input logic [MODE_W-1:0] mode,
                                      input logic [SPEED_W-1:0] b,
                                      input logic [SPEED_W-1:0] floor);
    move_t m;
    case (mode)
      MODE_STRAFE_LEFT: begin
        m.motion = MOT_STRAFE_LEFT;
        m.fl = clamp_speed(b, SL_FL, floor);
        m.rl = clamp_speed(b, SL_RL, floor);
        m.fr = clamp_speed(b, SL_FR, floor);
        m.rr = clamp_speed(b, SL_RR, floor);
      end
      MODE_STRAFE_RIGHT: begin
        m.motion = MOT_STRAFE_RIGHT;
        m.fl = clamp_speed(b, SR_FL, floor);
        m.rl = clamp_speed(b, SR_RL, floor);
        m.fr = clamp_speed(b, SR_FR, floor);
        m.rr = clamp_speed(b, SR_RR, floor);
      end
      default: begin
        m.motion = MOT_ADVANCE;
        m.fl = b;
        m.rl = b;
        m.fr = b;
        m.rr = b;
      end
    endcase
    return m;
  endfunction

endpackage

### src/ltjc_if.sv
// valid/ready channel interfaces for sensor beats and wheel command beats
interface ltjc_in_if;
  logic valid;
  logic ready;
  logic op;
  logic left_on;
  logic mid_on;
  logic right_on;
  logic estop;

  modport source (output valid, op, left_on, mid_on, right_on, estop, input ready);
  modport sink (input valid, op, left_on, mid_on, right_on, estop, output ready);
endinterface

interface ltjc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ltjc_pkg::MOTION_W-1:0] motion;
  logic [ltjc_pkg::SPEED_W-1:0]  speed_front_left;
  logic [ltjc_pkg::SPEED_W-1:0]  speed_rear_left;
  logic [ltjc_pkg::SPEED_W-1:0]  speed_front_right;
  logic [ltjc_pkg::SPEED_W-1:0]  speed_rear_right;
  logic [ltjc_pkg::EDGES_W-1:0]  edges_counted;
  logic                          finished;
  logic                          aborted;
  logic [ltjc_pkg::OFFSET_W-1:0] nudge_ms;

  modport source (output valid, motion, speed_front_left, speed_rear_left, speed_front_right,
                  speed_rear_right, edges_counted, finished, aborted, nudge_ms, input ready);
  modport sink (input valid, motion, speed_front_left, speed_rear_left, speed_front_right,
                speed_rear_right, edges_counted, finished, aborted, nudge_ms, output ready);
endinterface

### src/line_track_junction_counter_unit.sv
// top level of the line track junction counter: config registers, step logic, output buffer
//
//   channel   dir  handshake     beat contents
//   in_i      in   valid/ready   op, left_on, mid_on, right_on, estop
//   out_o     out  valid/ready   motion, four wheel speeds, edges_counted, finished,
//                                aborted, nudge_ms
//   cfg       in   cfg_we_i      cfg_idx_i selects the register, cfg_data_i the value
//
// one beat per cycle while in_i is ready; each result is registered in the output buffer
// the decode is a single combinational pass from run state and config to the result
// a two-entry output buffer keeps in_i ready for one more beat while out_o stalls
// reset clears the run state and loads the register defaults
module line_track_junction_counter_unit #(
  parameter int unsigned COUNT_BITS = ltjc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ltjc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ltjc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ltjc_in_if.sink                         in_i,
  ltjc_out_if.source                      out_o
);
  import ltjc_pkg::*;

  cfg_t    cfg_q;
  result_t step_res, buf_res;
  logic    accept;
  logic    buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= RST_MODE;
      cfg_q.target     <= RST_TARGET;
      cfg_q.start      <= RST_START;
      cfg_q.floor      <= RST_FLOOR;
      cfg_q.end_offset <= RST_END_OFFSET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:       cfg_q.mode       <= cfg_data_i[MODE_W-1:0];
        CFG_TARGET:     cfg_q.target     <= cfg_data_i[TARGET_W-1:0];
        CFG_START:      cfg_q.start      <= cfg_data_i[SPEED_W-1:0];
        CFG_FLOOR:      cfg_q.floor      <= cfg_data_i[SPEED_W-1:0];
        CFG_END_OFFSET: cfg_q.end_offset <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  ltjc_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (in_i.op),
    .left_on_i  (in_i.left_on),
    .mid_on_i   (in_i.mid_on),
    .right_on_i (in_i.right_on),
    .estop_i    (in_i.estop),
    .cfg_i      (cfg_q),
    .res_o      (step_res)
  );

  ltjc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (step_res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (buf_res)
  );

  assign out_o.motion            = buf_res.move.motion;
  assign out_o.speed_front_left  = buf_res.move.fl;
  assign out_o.speed_rear_left   = buf_res.move.rl;
  assign out_o.speed_front_right = buf_res.move.fr;
  assign out_o.speed_rear_right  = buf_res.move.rr;
  assign out_o.edges_counted     = buf_res.edges;
  assign out_o.finished          = buf_res.finished;
  assign out_o.aborted           = buf_res.aborted;
  assign out_o.nudge_ms          = buf_res.nudge;

endmodule

### src/ltjc_step.sv
// run state and per-beat decode of edge count, speed ramp and wheel command
module ltjc_step #(
  parameter int unsigned COUNT_BITS = ltjc_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              op_i,
  input  logic              left_on_i,
  input  logic              mid_on_i,
  input  logic              right_on_i,
  input  logic              estop_i,
  input  ltjc_pkg::cfg_t    cfg_i,
  output ltjc_pkg::result_t res_o
);
  import ltjc_pkg::*;

  localparam int unsigned KW = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;
  localparam int unsigned RW = COUNT_BITS + 3;
  localparam int unsigned CW = (RW > SPEED_W) ? RW : SPEED_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  on_q, on_d;
  logic                  run_q, run_d;

  logic [KW-1:0]      cnt_ext, inc_ext, tgt_ext, edges_ext;
  logic [CW-1:0]      ramp, start_ext, diff;
  logic [SPEED_W-1:0] base;
  logic [SPEED_W:0]   turn_sum;
  logic [SPEED_W-1:0] turn;
  logic               pat;
  logic               finish_hit;
  move_t              cur_move, fin_move;
  result_t            res;

  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign cnt_ext = KW'(cnt_q);
  assign inc_ext = KW'(cnt_inc);
  assign tgt_ext = KW'(cfg_i.target);

  // ramped base speed with floor
  assign ramp      = CW'(cnt_q) * CW'(RAMP_STEP);
  assign start_ext = CW'(cfg_i.start);
  assign diff      = start_ext - ramp;
  always_comb begin
    if (ramp > start_ext) begin
      base = cfg_i.floor;
    end else if (diff[SPEED_W-1:0] < cfg_i.floor) begin
      base = cfg_i.floor;
    end else begin
      base = diff[SPEED_W-1:0];
    end
  end

  assign turn_sum = {1'b0, base} + {1'b0, TURN_BOOST};
  assign turn     = turn_sum[SPEED_W] ? {SPEED_W{1'b1}} : turn_sum[SPEED_W-1:0];

  always_comb begin
    case (cfg_i.mode)
      MODE_FORWARD:     pat = left_on_i && mid_on_i && right_on_i;
      MODE_MARKER:      pat = mid_on_i && right_on_i;
      MODE_STRAFE_LEFT: pat = left_on_i;
      default:          pat = right_on_i;
    endcase
  end

  assign cur_move = mode_move(cfg_i.mode, base, cfg_i.floor);
  assign fin_move = mode_move(cfg_i.mode, cfg_i.floor, cfg_i.floor);

  always_comb begin
    cnt_d      = cnt_q;
    on_d       = on_q;
    run_d      = run_q;
    finish_hit = 1'b0;
    res        = '0;
    res.move.motion = MOT_STOP;
    if (!op_i) begin
      cnt_d = '0;
      on_d  = 1'b1;
      run_d = 1'b1;
      if (cfg_i.target == '0) begin
        run_d      = 1'b0;
        finish_hit = 1'b1;
      end
    end else if (run_q) begin
      if (cnt_ext >= tgt_ext) begin
        run_d      = 1'b0;
        finish_hit = (cnt_ext == tgt_ext);
      end else begin
        if (pat) begin
          if (!on_q) begin
            cnt_d = cnt_inc;
            on_d  = 1'b1;
          end
          if (!on_q && inc_ext == tgt_ext) begin
            run_d      = 1'b0;
            finish_hit = 1'b1;
          end else begin
            res.move = cur_move;
          end
        end else if (cfg_i.mode == MODE_STRAFE_LEFT || cfg_i.mode == MODE_STRAFE_RIGHT) begin
          on_d     = 1'b0;
          res.move = cur_move;
        end else if (left_on_i && !mid_on_i && right_on_i) begin
          res.move.motion = MOT_HOLD;
        end else begin
          on_d = 1'b0;
          if (left_on_i && !right_on_i) begin
            res.move = '{motion: MOT_TURN_LEFT, fl: turn, rl: turn, fr: turn, rr: turn};
          end else if (right_on_i && !left_on_i) begin
            res.move = '{motion: MOT_TURN_RIGHT, fl: turn, rl: turn, fr: turn, rr: turn};
          end else begin
            res.move = '{motion: MOT_ADVANCE, fl: base, rl: base, fr: base, rr: base};
          end
        end
        if (estop_i && !finish_hit) begin
          run_d           = 1'b0;
          res.move        = '0;
          res.move.motion = MOT_STOP;
          res.aborted     = 1'b1;
        end
      end
    end
    if (finish_hit) begin
      res.finished = 1'b1;
      res.nudge    = cfg_i.end_offset;
      if (cfg_i.end_offset != '0) begin
        res.move = fin_move;
      end
    end
    edges_ext = KW'(cnt_d);
    res.edges = edges_ext[EDGES_W-1:0];
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      on_q  <= 1'b1;
      run_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      on_q  <= on_d;
      run_q <= run_d;
    end
  end

endmodule

### src/ltjc_skid.sv
// two-entry output register with skid slot for result beats
module ltjc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ltjc_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ltjc_pkg::result_t out_data_o
);
  import ltjc_pkg::*;

  result_t main_q, spare_q;
  logic    main_vld_q, main_vld_d;
  logic    spare_vld_q, spare_vld_d;
  logic    push, pop;

  assign in_ready_o  = !spare_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;
  assign push        = in_valid_i && !spare_vld_q;
  assign pop         = main_vld_q && out_ready_i;

  always_comb begin
    main_vld_d  = main_vld_q;
    spare_vld_d = spare_vld_q;
    if (spare_vld_q) begin
      if (pop) begin
        spare_vld_d = 1'b0;
      end
    end else if (push) begin
      main_vld_d = 1'b1;
      if (main_vld_q && !pop) begin
        spare_vld_d = 1'b1;
      end
    end else if (pop) begin
      main_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q  <= 1'b0;
      spare_vld_q <= 1'b0;
    end else begin
      main_vld_q  <= main_vld_d;
      spare_vld_q <= spare_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_vld_q) begin
      if (pop) begin
        main_q <= spare_q;
      end
    end else if (push) begin
      if (!main_vld_q || pop) begin
        main_q <= in_data_i;
      end else begin
        spare_q <= in_data_i;
      end
    end
  end

endmodule
